// ----- rtl/utf8dc_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Types and constants shared by the UTF-8 decoder and character counter.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

    localparam int CP_W       = 21;
    localparam int OUT_CNT_W  = 16;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [2:0] LEAD2_TAG  = 3'b110;
    localparam logic [3:0] LEAD3_TAG  = 4'b1110;
    localparam logic [4:0] LEAD4_TAG  = 5'b11110;

    localparam logic [1:0] REM_NONE   = 2'd0;
    localparam logic [1:0] REM_ONE    = 2'd1;
    localparam logic [1:0] REM_TWO    = 2'd2;
    localparam logic [1:0] REM_THREE  = 2'd3;

    localparam logic [31:0] OUT_CNT_MAX = 32'h0000_FFFF;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0]      code_point;
        logic                 point_valid;
        logic                 is_error;
        logic                 string_done;
        logic [OUT_CNT_W-1:0] char_count;
    } result_item_t;

endpackage

// ----- rtl/utf8_decode_and_count.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_and_count
// Streaming UTF-8 decoder with a saturating character counter.
// ----------------------------------------------------------------------------
// One byte request is taken per clock cycle while byte_stall is low. Each byte
// passes through an input register, the decode logic and a result register. A
// result is written to the result register when its byte leaves the input
// register, and is held there until the receiver takes it. Bytes that complete
// no character, raise no error and do not end the string give no result. A
// stalled result holds the byte behind it in the input register, and the
// pipeline resumes at full rate as soon as the stall is released. The count
// saturates at 2^COUNT_BITS - 1 and is reported up to 65535.
// ----------------------------------------------------------------------------
module utf8_decode_and_count
    import utf8dc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    logic         held_valid;
    byte_item_t   held_item;
    logic         room;
    logic         fire;
    logic         has_result;
    result_item_t core_result;

    assign fire = held_valid && room;

    utf8dc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .take       (room),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    utf8dc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (held_item),
        .has_result (has_result),
        .result     (core_result)
    );

    utf8dc_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && has_result),
        .load_item    (core_result),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ----- rtl/utf8dc_in_stage.sv -----
// ----------------------------------------------------------------------------
// utf8dc_in_stage
// Input register: holds one byte request until the decode stage takes it.
// ----------------------------------------------------------------------------
module utf8dc_in_stage
    import utf8dc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    input  logic       take,
    output logic       held_valid,
    output byte_item_t held_item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    assign byte_stall = valid_reg && !take;
    assign valid_next = byte_stall ? valid_reg : byte_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_reg <= byte_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- rtl/utf8dc_core.sv -----
// ----------------------------------------------------------------------------
// utf8dc_core
// Decoder state and the per-byte decode, count and error logic.
// ----------------------------------------------------------------------------
module utf8dc_core
    import utf8dc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  byte_item_t   item,
    output logic         has_result,
    output result_item_t result
);

    logic [1:0]            rem_reg;
    logic [1:0]            rem_next;
    logic [CP_W-1:0]       acc_reg;
    logic [CP_W-1:0]       acc_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  skip_reg;
    logic                  skip_next;

    logic [7:0]            b;
    logic                  last;
    logic [CP_W-1:0]       cp;
    logic                  valid;
    logic                  err;
    logic [1:0]            rem_step;
    logic [CP_W-1:0]       acc_step;
    logic [COUNT_BITS-1:0] count_step;
    logic [31:0]           count_wide;

    assign b    = item.byte_in;
    assign last = item.last_byte;

    always_comb
    begin
        cp       = '0;
        valid    = 1'b0;
        err      = 1'b0;
        rem_step = rem_reg;
        acc_step = acc_reg;
        if (skip_reg)
        begin
            err = last;
        end
        else if (rem_reg == REM_NONE)
        begin
            priority if (!b[7])
            begin
                cp    = CP_W'(b);
                valid = 1'b1;
            end
            else if (b[7:5] == LEAD2_TAG)
            begin
                acc_step = CP_W'(b[4:0]);
                rem_step = REM_ONE;
            end
            else if (b[7:4] == LEAD3_TAG)
            begin
                acc_step = CP_W'(b[3:0]);
                rem_step = REM_TWO;
            end
            else if (b[7:3] == LEAD4_TAG)
            begin
                acc_step = CP_W'(b[2:0]);
                rem_step = REM_THREE;
            end
            else
            begin
                err = 1'b1;
            end
        end
        else if ((b & CONT_MASK) == CONT_TAG)
        begin
            acc_step = {acc_reg[CP_W-7:0], b[5:0]};
            rem_step = rem_reg - REM_ONE;
            if (rem_step == REM_NONE)
            begin
                cp    = acc_step;
                valid = 1'b1;
            end
        end
        else
        begin
            err = 1'b1;
        end

        if (!err && !valid && last && (rem_step != REM_NONE))
        begin
            err = 1'b1;
        end
    end

    assign count_step = (valid && (count_reg != '1)) ? count_reg + 1'b1 : count_reg;
    assign count_wide = 32'(count_step);

    always_comb
    begin
        rem_next   = rem_step;
        acc_next   = acc_step;
        count_next = count_step;
        skip_next  = skip_reg;
        if (err)
        begin
            skip_next = 1'b1;
            rem_next  = REM_NONE;
            acc_next  = '0;
        end
        if (last)
        begin
            rem_next   = REM_NONE;
            acc_next   = '0;
            count_next = '0;
            skip_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= REM_NONE;
            acc_reg   <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b0;
        end
        else if (fire)
        begin
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

    assign has_result         = valid || err || last;
    assign result.code_point  = cp;
    assign result.point_valid = valid;
    assign result.is_error    = err;
    assign result.string_done = last;
    assign result.char_count  = (count_wide > OUT_CNT_MAX) ? '1 : count_wide[OUT_CNT_W-1:0];

endmodule

// ----- rtl/utf8dc_out_stage.sv -----
// ----------------------------------------------------------------------------
// utf8dc_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module utf8dc_out_stage
    import utf8dc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_item_t load_item,
    output logic         room,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    logic         valid_reg;
    logic         valid_next;
    result_item_t item_reg;

    assign room       = !valid_reg || !result_stall;
    assign valid_next = room ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            item_reg <= load_item;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = item_reg;

endmodule
